/* rtl/uvr_pkg.sv */
`default_nettype none

package uvr_pkg;

  // One input beat: a screen-space direction and a rotation.
  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] rotate_angle;
  } vec_in_t;

  // One output beat: the unit vector (cos, -sin) at the new angle.
  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
  } vec_out_t;

  // Datapath widths of the two CORDIC pipelines.
  localparam int VEC_W = 27;
  localparam int ROT_W = 33;

  // Arctangent table length, full turn in 1/64 degree, and CORDIC gain in Q30.
  localparam int ATAN_COUNT = 24;
  localparam int TURN_64THS = 23040;
  localparam int GAIN_Q30   = 652032874;

  // State of one item inside the vectoring pipeline.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;
    logic                    zero;
    logic signed [15:0]      rot;
  } vec_state_t;

  // State of one item inside the rotation pipeline.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [31:0]      r;
    logic                    flip;
  } rot_state_t;

  // Arctangent of 2^-idx in turn units (one turn is 2^32).
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/uvr_vec_pipe.sv */
`default_nettype none

module uvr_vec_pipe #(
  parameter int STEPS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire uvr_pkg::vec_state_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output uvr_pkg::vec_state_t      out_data
);
  import uvr_pkg::*;

  vec_state_t       st [STEPS];
  vec_state_t       st_next [STEPS];
  logic [STEPS-1:0] vld;
  logic [STEPS:0]   adv;

  // A stage moves when it is empty or the stage after it moves.
  assign adv[STEPS] = out_ready;
  for (genvar k = 0; k < STEPS; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  // One vectoring micro-rotation per stage: drive y toward zero.
  always_comb begin
    vec_state_t              src;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    for (int k = 0; k < STEPS; k++) begin
      src = (k == 0) ? in_data : st[(k == 0) ? 0 : k-1];
      dx = src.y >>> k;
      dy = src.x >>> k;
      st_next[k] = src;
      if (!src.y[VEC_W-1]) begin
        st_next[k].x = src.x + dx;
        st_next[k].y = src.y - dy;
        st_next[k].z = src.z + atan_turn(k);
      end else begin
        st_next[k].x = src.x - dx;
        st_next[k].y = src.y + dy;
        st_next[k].z = src.z - atan_turn(k);
      end
    end
  end

  // Stage registers with their valid bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < STEPS; k++) begin
      if (adv[k]) begin
        st[k] <= st_next[k];
      end
    end
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_data  = st[STEPS-1];

endmodule

`default_nettype wire

/* rtl/uvr_rot_pipe.sv */
`default_nettype none

module uvr_rot_pipe #(
  parameter int STEPS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire uvr_pkg::rot_state_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output uvr_pkg::rot_state_t      out_data
);
  import uvr_pkg::*;

  rot_state_t       st [STEPS];
  rot_state_t       st_next [STEPS];
  logic [STEPS-1:0] vld;
  logic [STEPS:0]   adv;

  // A stage moves when it is empty or the stage after it moves.
  assign adv[STEPS] = out_ready;
  for (genvar k = 0; k < STEPS; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  // One rotation micro-step per stage: drive the residual angle toward zero.
  always_comb begin
    rot_state_t              src;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    for (int k = 0; k < STEPS; k++) begin
      src = (k == 0) ? in_data : st[(k == 0) ? 0 : k-1];
      dx = src.y >>> k;
      dy = src.x >>> k;
      st_next[k] = src;
      if (!src.r[31]) begin
        st_next[k].x = src.x - dx;
        st_next[k].y = src.y + dy;
        st_next[k].r = src.r - $signed(atan_turn(k));
      end else begin
        st_next[k].x = src.x + dx;
        st_next[k].y = src.y - dy;
        st_next[k].r = src.r + $signed(atan_turn(k));
      end
    end
  end

  // Stage registers with their valid bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < STEPS; k++) begin
      if (adv[k]) begin
        st[k] <= st_next[k];
      end
    end
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_data  = st[STEPS-1];

endmodule

`default_nettype wire

/* rtl/unit_vector_rotate.sv */
// Channel   Beat type   Handshake             Carries
// req       vec_in_t    req_valid/req_stall   direction (Q2.14) and rotation (1/64 deg)
// rsp       vec_out_t   rsp_valid/rsp_stall   unit vector (cos, -sin) in Q1.14
//
// One beat is taken every cycle unless rsp_stall backs up the pipeline and raises req_stall.
// Stages: input prep, STEPS vectoring steps (CORDIC_STEPS capped at ATAN_COUNT),
// four angle stages (scale, wrap, two for turn conversion), STEPS rotation steps, output.
// Each stage has its own valid bit and moves when empty or when its successor
// moves, so bubbles close up while a result waits under rsp_stall.
// Reset clears all valid bits; no payload register is reset.
`default_nettype none

module unit_vector_rotate #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_stall,
  input  wire uvr_pkg::vec_in_t  req,
  output logic                   rsp_valid,
  input  wire                    rsp_stall,
  output uvr_pkg::vec_out_t      rsp
);
  import uvr_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;

  // Handshake between stages.
  logic adv_p, adv_a, adv_b, adv_c, adv_d, adv_o;
  logic vec_ready, rot_ready;
  logic vec_valid, rot_valid;

  // Stage registers.
  logic        p_valid, a_valid, b_valid, c_valid, d_valid;
  vec_state_t  p_st, p_next, vec_st;
  logic [46:0] a_prod;
  logic signed [15:0] a_rot;
  logic [14:0] b_s;
  logic [31:0] c_p1;
  logic [39:0] c_p2;
  rot_state_t  d_st, d_next, rot_st;
  vec_out_t    rsp_next;

  assign adv_o = !rsp_valid || !rsp_stall;
  assign adv_d = !d_valid || rot_ready;
  assign adv_c = !c_valid || adv_d;
  assign adv_b = !b_valid || adv_c;
  assign adv_a = !a_valid || adv_b;
  assign adv_p = !p_valid || vec_ready;
  assign req_stall = !adv_p;

  // Input prep: scale by 256, flip y to math orientation, fold the left half plane.
  always_comb begin
    logic signed [VEC_W-1:0] px;
    logic signed [VEC_W-1:0] py;
    px = VEC_W'(req.vec_x) <<< 8;
    py = -(VEC_W'(req.vec_y) <<< 8);
    p_next.zero = (req.vec_x == 16'sd0) && (req.vec_y == 16'sd0);
    p_next.rot  = req.rotate_angle;
    if (px[VEC_W-1]) begin
      p_next.x = -px;
      p_next.y = -py;
      p_next.z = 32'h8000_0000;
    end else begin
      p_next.x = px;
      p_next.y = py;
      p_next.z = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p) begin
      p_st <= p_next;
    end
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv_p) begin
      p_valid <= req_valid;
    end
  end

  uvr_vec_pipe #(
    .STEPS (STEPS)
  ) u_vec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (vec_ready),
    .in_data   (p_st),
    .out_valid (vec_valid),
    .out_ready (adv_a),
    .out_data  (vec_st)
  );

  // Scale the turn angle to 1/64 degree with rounding; a zero vector has angle 0.
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_prod <= 47'(vec_st.zero ? 32'h0 : vec_st.z) * 47'(TURN_64THS) + 47'h8000_0000;
      a_rot  <= vec_st.rot;
    end
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= vec_valid;
    end
  end

  // Add the rotation and wrap modulo one turn.
  logic [14:0] b_next;
  always_comb begin
    logic [14:0]        a64;
    logic signed [17:0] sum;
    logic [16:0]        v;
    a64 = a_prod[46:32];
    if (a64 >= 15'(TURN_64THS)) begin
      a64 = '0;
    end
    sum = $signed({3'b000, a64}) + 18'(a_rot);
    v = 17'(sum + 18'sd46080);
    if (v >= 17'd92160) begin
      v = v - 17'd92160;
    end else if (v >= 17'd69120) begin
      v = v - 17'd69120;
    end else if (v >= 17'd46080) begin
      v = v - 17'd46080;
    end else if (v >= 17'd23040) begin
      v = v - 17'd23040;
    end
    b_next = 15'(v);
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_s <= b_next;
    end
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv_b) begin
      b_valid <= a_valid;
    end
  end

  // Turn angle t = floor((s*2^23 + 22) / 45): whole part and a reciprocal
  // multiply for the remainder term floor((23*s + 22) / 45).
  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_p1 <= 32'(b_s) * 32'd186413;
      c_p2 <= 40'(b_s) * 40'd34300107 + 40'd32808798;
    end
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv_c) begin
      c_valid <= b_valid;
    end
  end

  // Finish the turn angle and fold the back half circle.
  always_comb begin
    logic [31:0] t;
    t = c_p1 + 32'(c_p2[39:26]);
    d_next.flip = t[31] ^ t[30];
    d_next.r    = $signed(d_next.flip ? (t ^ 32'h8000_0000) : t);
    d_next.x    = ROT_W'(GAIN_Q30);
    d_next.y    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      d_st <= d_next;
    end
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv_d) begin
      d_valid <= c_valid;
    end
  end

  uvr_rot_pipe #(
    .STEPS (STEPS)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (rot_ready),
    .in_data   (d_st),
    .out_valid (rot_valid),
    .out_ready (adv_o),
    .out_data  (rot_st)
  );

  // Round a Q30 value to Q14 and clamp to the unit range.
  function automatic logic signed [15:0] to_q14(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] w;
    w = (v + $signed(ROT_W'(32768))) >>> 16;
    if (w > $signed(ROT_W'(16384))) begin
      w = $signed(ROT_W'(16384));
    end else if (w < -$signed(ROT_W'(16384))) begin
      w = -$signed(ROT_W'(16384));
    end
    return 16'(w);
  endfunction

  // Output: undo the half-turn fold, round, and negate the sine.
  always_comb begin
    logic signed [ROT_W-1:0] xf;
    logic signed [ROT_W-1:0] yf;
    xf = rot_st.flip ? -rot_st.x : rot_st.x;
    yf = rot_st.flip ? -rot_st.y : rot_st.y;
    rsp_next.rot_x = to_q14(xf);
    rsp_next.rot_y = -to_q14(yf);
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv_o) begin
      rsp_valid <= rot_valid;
    end
  end

`ifndef SYNTHESIS
  // A held result stays valid until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !adv_c) |=> b_valid)
    else $error("wrap stage lost a beat while held");

  // The wrapped angle is always below one turn.
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_s < 15'(TURN_64THS)))
    else $error("wrapped angle out of range");

  // After folding, the residual angle lies within a quarter turn.
  assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (d_st.r[31] == d_st.r[30]))
    else $error("folded angle outside a quarter turn");

  // Outputs stay in the clamped unit range.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.rot_x <= 16'sd16384 && rsp.rot_x >= -16'sd16384 &&
                   rsp.rot_y <= 16'sd16384 && rsp.rot_y >= -16'sd16384))
    else $error("result outside unit range");

  // Reset empties the output stage.
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
